// ----- hw/rtl/int_to_ascii_digits_top_assert.svh -----
// Assertion macros shared by the RTL of the integer to ASCII converter.
`ifndef INT_TO_ASCII_DIGITS_TOP_ASSERT_SVH
`define INT_TO_ASCII_DIGITS_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ITAD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itad assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ITAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itad assertion failed");

`endif

// ----- hw/rtl/itad_pkg.sv -----
// Package with the types, constants and digit table of the integer to ASCII converter.
`timescale 1ns / 1ps

package itad_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 7;
    localparam int VALUE_BITS_DEF = 32;

    // ASCII code of the minus sign.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    // Converter sequencing states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    // Lower-case digit characters, indexed by digit value.
    localparam logic [CHAR_W-1:0] DIGIT_TABLE [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    // Maps one 4-bit digit to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] dig);
        return DIGIT_TABLE[dig];
    endfunction

endpackage

// ----- hw/rtl/int_to_ascii_digits_top.sv -----
// Integer to ASCII converter: signed decimal or unsigned hex text, one character per transfer.
//
// Each accepted number is turned into its text, most significant digit first, with last
// set on the final character; zero gives a single '0' and decimal negatives get a leading
// '-'. The block works on one number at a time. After the input transfer it converts,
// taking one 4-bit slice of the magnitude per cycle into a chain of 4-bit digits
// (shift-and-add-3 in decimal, a plain nibble shift in hex). It then walks the digit
// chain from the top, one digit per cycle, either dropping a leading zero or sending a
// character, which waits while the output register is full and stalled. The minus sign
// goes out as soon as the output register is free, ahead of any digit. A new number is
// taken while the final character still waits in the output register.
`timescale 1ns / 1ps

module int_to_ascii_digits_top #(
    parameter int VALUE_BITS = itad_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [itad_pkg::VALUE_W-1:0] value,
    input  logic                               hex_mode,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [itad_pkg::CHAR_W-1:0]        character,
    output logic                               last
);

    import itad_pkg::*;

    // Sizes derived from the value width.
    localparam int NIBBLES    = (VALUE_BITS + 3) / 4;
    localparam int PAD_BITS   = NIBBLES * 4;
    localparam int DEC_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
    localparam int N_DIGITS   = (DEC_DIGITS > NIBBLES) ? DEC_DIGITS : NIBBLES;
    localparam int DIG_W      = N_DIGITS * 4;
    localparam int STEP_W     = $clog2(NIBBLES + 1);
    localparam int CNT_W      = $clog2(N_DIGITS + 1);

    // Control registers.
    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               started_reg, started_next;
    logic               sign_pend_reg, sign_pend_next;
    logic               out_valid_reg, out_valid_next;

    // Payload registers.
    logic [DIG_W-1:0]    digits_reg, digits_next;
    logic [PAD_BITS-1:0] mag_reg, mag_next;
    logic                hex_reg, hex_next;
    logic [CHAR_W-1:0]   character_reg, character_next;
    logic                last_reg, last_next;

    // Handshake and sequencing terms.
    logic                  in_xfer;
    logic                  out_free;
    logic [3:0]            top_digit;
    logic                  cnt_last;
    logic                  skip_zero;
    logic                  emit_sign;
    logic                  emit_digit;
    logic [VALUE_BITS-1:0] in_bits;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic [DIG_W-1:0]      dd_chain;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    // Magnitude of the incoming number; only decimal mode treats the top bit as a sign.
    assign in_bits = value[VALUE_BITS-1:0];
    assign in_neg  = !hex_mode && in_bits[VALUE_BITS-1];
    assign in_mag  = in_neg ? (~in_bits + VALUE_BITS'(1)) : in_bits;

    // Digit walk: leading zeros are dropped, the final digit always goes out.
    assign top_digit  = digits_reg[DIG_W-1 -: 4];
    assign cnt_last   = (cnt_reg == CNT_W'(1));
    assign skip_zero  = (state_reg == ST_EMIT) && !started_reg &&
                        (top_digit == 4'd0) && !cnt_last;
    assign emit_sign  = sign_pend_reg && out_free;
    assign emit_digit = (state_reg == ST_EMIT) && !skip_zero && !sign_pend_reg && out_free;

    // One conversion step: four bits of magnitude enter the digit chain.
    always_comb
    begin
        dd_chain = digits_reg;
        if (hex_reg)
        begin
            dd_chain = {digits_reg[DIG_W-5:0], mag_reg[PAD_BITS-1 -: 4]};
        end
        else
        begin
            for (int b = 0; b < 4; b++)
            begin
                for (int d = 0; d < N_DIGITS; d++)
                begin
                    if (dd_chain[d*4 +: 4] >= 4'd5)
                    begin
                        dd_chain[d*4 +: 4] = dd_chain[d*4 +: 4] + 4'd3;
                    end
                end
                dd_chain = {dd_chain[DIG_W-2:0], mag_reg[PAD_BITS-1-b]};
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_digit && cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register next values.
    always_comb
    begin
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        started_next   = started_reg;
        sign_pend_next = sign_pend_reg;
        digits_next    = digits_reg;
        mag_next       = mag_reg;
        hex_next       = hex_reg;
        out_valid_next = out_valid_reg;
        character_next = character_reg;
        last_next      = last_reg;

        if (out_free)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    step_next      = STEP_W'(NIBBLES);
                    cnt_next       = CNT_W'(N_DIGITS);
                    started_next   = 1'b0;
                    sign_pend_next = in_neg;
                    digits_next    = '0;
                    mag_next       = PAD_BITS'(in_mag);
                    hex_next       = hex_mode;
                end
            end
            ST_CONVERT:
            begin
                step_next   = step_reg - STEP_W'(1);
                digits_next = dd_chain;
                mag_next    = {mag_reg[PAD_BITS-5:0], 4'd0};
            end
            ST_EMIT:
            begin
                if (skip_zero || emit_digit)
                begin
                    digits_next = {digits_reg[DIG_W-5:0], 4'd0};
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
                if (emit_digit)
                begin
                    started_next   = 1'b1;
                    out_valid_next = 1'b1;
                    character_next = digit_char(top_digit);
                    last_next      = cnt_last;
                end
            end
            default:
            begin
            end
        endcase

        // The minus sign leaves ahead of any digit.
        if (emit_sign)
        begin
            sign_pend_next = 1'b0;
            out_valid_next = 1'b1;
            character_next = CHAR_MINUS;
            last_next      = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
            sign_pend_reg <= sign_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        digits_reg    <= digits_next;
        mag_reg       <= mag_next;
        hex_reg       <= hex_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    // Checks on the sequencing.
`include "int_to_ascii_digits_top_assert.svh"

    `ITAD_ASSERT_NOW(a_minus_not_last, out_valid_reg && (character_reg == CHAR_MINUS), !last_reg)
    `ITAD_ASSERT_NEXT(a_done_has_last, (state_reg == ST_EMIT) && (state_next == ST_IDLE), out_valid_reg && last_reg)
    `ITAD_ASSERT_NOW(a_emit_has_digits, state_reg == ST_EMIT, cnt_reg != '0)
    `ITAD_ASSERT_NOW(a_idle_no_sign, state_reg == ST_IDLE, !sign_pend_reg)

endmodule
